// ----- src/button_auto_repeat_setpoint_core_assert.svh -----
// Assertion macros for the button auto-repeat setpoint block.
// Included by the modules that check their own logic; no other dependencies.
`ifndef BUTTON_AUTO_REPEAT_SETPOINT_CORE_ASSERT_SVH
`define BUTTON_AUTO_REPEAT_SETPOINT_CORE_ASSERT_SVH

// Consequent checked on the cycle after the antecedent.
`define BRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("brs assertion failed: next-cycle check");

// Consequent checked in the same cycle as the antecedent.
`define BRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("brs assertion failed: same-cycle check");

`endif

// ----- src/brs_pkg.sv -----
// Shared types and constants for the button auto-repeat setpoint block.
// No dependencies.
package brs_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_WAIT   = 2'd1,
        MODE_REPEAT = 2'd2
    } t_mode;

    typedef enum logic {
        BTN_UP   = 1'b0,
        BTN_DOWN = 1'b1
    } t_btn;

    typedef enum logic [1:0] {
        CFG_SETPOINT_MIN  = 2'd0,
        CFG_SETPOINT_MAX  = 2'd1,
        CFG_HOLD_DELAY    = 2'd2,
        CFG_REPEAT_PERIOD = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  setpoint_min;
        logic [7:0]  setpoint_max;
        logic [15:0] hold_delay;
        logic [15:0] repeat_period;
    } t_cfg;

    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned COUNT_W = 16;

    localparam logic [LEVEL_W-1:0] RST_SETPOINT_MIN  = 8'd16;
    localparam logic [LEVEL_W-1:0] RST_SETPOINT_MAX  = 8'd30;
    localparam logic [COUNT_W-1:0] RST_HOLD_DELAY    = 16'd500;
    localparam logic [COUNT_W-1:0] RST_REPEAT_PERIOD = 16'd100;
    localparam logic [LEVEL_W-1:0] RST_LEVEL         = 8'd16;

endpackage

// ----- src/brs_cfg.sv -----
// Configuration register file: min/max limits, hold delay, repeat period.
// Depends on brs_pkg.
module brs_cfg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  brs_pkg::t_cfg_idx     i_idx,
    input  logic [15:0]           i_data,
    output brs_pkg::t_cfg         o_cfg
);
    import brs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint_min  <= RST_SETPOINT_MIN;
            r_cfg.setpoint_max  <= RST_SETPOINT_MAX;
            r_cfg.hold_delay    <= RST_HOLD_DELAY;
            r_cfg.repeat_period <= RST_REPEAT_PERIOD;
        end else if (i_wr) begin
            unique case (i_idx)
                CFG_SETPOINT_MIN:  r_cfg.setpoint_min  <= i_data[LEVEL_W-1:0];
                CFG_SETPOINT_MAX:  r_cfg.setpoint_max  <= i_data[LEVEL_W-1:0];
                CFG_HOLD_DELAY:    r_cfg.hold_delay    <= i_data[COUNT_W-1:0];
                CFG_REPEAT_PERIOD: r_cfg.repeat_period <= i_data[COUNT_W-1:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/brs_step.sv -----
// Setpoint state machine: countdown, phase and level, updated once per tick.
// Depends on brs_pkg and button_auto_repeat_setpoint_core_assert.svh.
module brs_step (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_up,
    input  logic                  i_down,
    input  brs_pkg::t_cfg         i_cfg,
    output logic [7:0]            o_level,
    output brs_pkg::t_mode        o_mode
);
    import brs_pkg::*;

    t_mode               r_mode, n_mode;
    t_btn                r_held, n_held;
    logic [COUNT_W-1:0]  r_cd, n_cd;
    logic [LEVEL_W-1:0]  r_level, n_level;

    logic [COUNT_W-1:0]  dec_cd;
    logic                held_lvl;
    logic                can_up;
    logic                can_dn;

    assign dec_cd   = (r_cd != '0) ? r_cd - COUNT_W'(1) : '0;
    assign held_lvl = (r_held == BTN_UP) ? i_up : i_down;
    assign can_up   = r_level < i_cfg.setpoint_max;
    assign can_dn   = r_level > i_cfg.setpoint_min;

    always_comb begin
        n_mode  = r_mode;
        n_held  = r_held;
        n_cd    = dec_cd;
        n_level = r_level;
        unique case (r_mode)
            MODE_WAIT: begin
                if (!held_lvl) begin
                    n_mode = MODE_IDLE;
                    n_cd   = '0;
                end else if (dec_cd == '0) begin
                    n_mode = MODE_REPEAT;
                    n_cd   = i_cfg.repeat_period;
                end
            end
            MODE_REPEAT: begin
                if (!held_lvl) begin
                    n_mode = MODE_IDLE;
                    n_cd   = '0;
                end else if (dec_cd == '0) begin
                    n_cd = i_cfg.repeat_period;
                    if (r_held == BTN_UP) begin
                        if (can_up) n_level = r_level + LEVEL_W'(1);
                    end else begin
                        if (can_dn) n_level = r_level - LEVEL_W'(1);
                    end
                end
            end
            default: begin
                // idle, and the unused code which behaves as idle
                n_mode = MODE_IDLE;
                if (i_up) begin
                    // up wins; at the limit the down button is ignored
                    if (can_up) begin
                        n_level = r_level + LEVEL_W'(1);
                        n_mode  = MODE_WAIT;
                        n_held  = BTN_UP;
                        n_cd    = i_cfg.hold_delay;
                    end
                end else if (i_down) begin
                    if (can_dn) begin
                        n_level = r_level - LEVEL_W'(1);
                        n_mode  = MODE_WAIT;
                        n_held  = BTN_DOWN;
                        n_cd    = i_cfg.hold_delay;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_held  <= BTN_UP;
            r_cd    <= '0;
            r_level <= RST_LEVEL;
        end else if (i_adv) begin
            r_mode  <= n_mode;
            r_held  <= n_held;
            r_cd    <= n_cd;
            r_level <= n_level;
        end
    end

    assign o_level = r_level;
    assign o_mode  = r_mode;

`include "button_auto_repeat_setpoint_core_assert.svh"

    `BRS_ASSERT_NEXT(a_hold_without_tick, i_clk, i_rst_n, !i_adv,
        $stable(r_level) && $stable(r_mode) && $stable(r_cd))
    `BRS_ASSERT_NEXT(a_idle_no_press, i_clk, i_rst_n,
        i_adv && (r_mode == MODE_IDLE) && !i_up && !i_down,
        (r_mode == MODE_IDLE) && $stable(r_level))
    `BRS_ASSERT_NEXT(a_single_step, i_clk, i_rst_n, i_adv,
        (r_level == $past(r_level)) || (r_level == $past(r_level) + 8'd1) ||
        (r_level == $past(r_level) - 8'd1))
    `BRS_ASSERT_NEXT(a_release_to_idle, i_clk, i_rst_n,
        i_adv && ((r_mode == MODE_WAIT) || (r_mode == MODE_REPEAT)) && !held_lvl,
        (r_mode == MODE_IDLE) && (r_cd == '0))

endmodule

// ----- src/button_auto_repeat_setpoint_core.sv -----
// Top level of the button auto-repeat setpoint block: input register, tick
// state machine with its result register, configuration registers. Uses brs_pkg.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------
//  in      | to block  | i_in_valid / o_in_ready  | i_up_pressed, i_down_pressed
//  out     | from block| o_out_valid / i_out_ready| o_setpoint, o_phase
//  cfg     | to block  | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One tick item per clock while the output is not stalled. Each item passes the
// input register, then the state registers, which double as the result register.
// i_rst_n is synchronous, active low; it restores the register reset values.
// A stalled output holds the state; the input register still takes one item,
// after which o_in_ready drops until the output drains. cfg is always ready.
module button_auto_repeat_setpoint_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_up_pressed,
    input  logic        i_down_pressed,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_setpoint,
    output logic [1:0]  o_phase,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import brs_pkg::*;

    // input register
    logic r_in_valid;
    logic r_up;
    logic r_down;
    // result valid
    logic r_out_valid;

    logic   in_acc;
    logic   adv;
    t_cfg   cfg;
    t_mode  mode;

    // a tick moves into the result stage when that stage is empty or draining
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_acc || (r_in_valid && !adv);
        end
    end

    // button levels carry no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_up   <= i_up_pressed;
            r_down <= i_down_pressed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_cfg_ready = 1'b1;

    brs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_idx   (t_cfg_idx'(i_cfg_index)),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    brs_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_up    (r_up),
        .i_down  (r_down),
        .i_cfg   (cfg),
        .o_level (o_setpoint),
        .o_mode  (mode)
    );

    assign o_phase     = mode;
    assign o_out_valid = r_out_valid;

endmodule
